// ----- src/qte_pkg.sv -----
// qte_pkg: shared widths, codes, queue item type and arctangent table
// for the quaternion to euler angle block; no dependencies
package qte_pkg;

   localparam int DATA_WIDTH_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int INT_FRAC    = 22;
   localparam int IN_W        = INT_FRAC + 2;
   localparam int PROD_W      = 2 * IN_W;
   localparam int SUM_W       = 52;
   localparam int CW          = 64;
   localparam int ACC_W       = 36;
   localparam int NORM_BIT    = 58;
   localparam int NORM_STAGES = 6;
   localparam int CORDIC_PRE  = NORM_STAGES + 2;
   localparam int S28_W       = 29;
   localparam int RAD_W       = 58;
   localparam int ROOT_W      = 29;
   localparam int SQRT_STEPS  = 29;
   localparam int SQRT_LAT    = SQRT_STEPS + 1;
   localparam int THR_W       = 15;
   localparam int THR_RESET   = 8176;
   localparam int QUEUE_DEPTH = 4;
   localparam int HALF_PI_Q30 = 1686629713;

   localparam logic [1:0] POLE_NONE  = 2'd0;
   localparam logic [1:0] POLE_NORTH = 2'd1;
   localparam logic [1:0] POLE_SOUTH = 2'd2;

   localparam logic [1:0] ATT_CALC = 2'd0;
   localparam logic [1:0] ATT_POS  = 2'd1;
   localparam logic [1:0] ATT_NEG  = 2'd2;

   localparam logic REG_POLE_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [1:0]              pole;
      logic [1:0]              att;
      logic signed [SUM_W-1:0] ha_y;
      logic signed [SUM_W-1:0] ha_x;
      logic signed [SUM_W-1:0] ba_y;
      logic signed [SUM_W-1:0] ba_x;
      logic signed [S28_W-1:0] s28;
      logic [RAD_W-1:0]        sq;
   } qte_item_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0:  v = 31'h3243F6A8;
         5'd1:  v = 31'h1DAC6705;
         5'd2:  v = 31'h0FADBAFC;
         5'd3:  v = 31'h07F56EA6;
         5'd4:  v = 31'h03FEAB76;
         5'd5:  v = 31'h01FFD55B;
         5'd6:  v = 31'h00FFFAAA;
         5'd7:  v = 31'h007FFF55;
         5'd8:  v = 31'h003FFFEA;
         5'd9:  v = 31'h001FFFFD;
         5'd10: v = 31'h000FFFFF;
         5'd11: v = 31'h0007FFFF;
         5'd12: v = 31'h0003FFFF;
         5'd13: v = 31'h0001FFFF;
         5'd14: v = 31'h0000FFFF;
         5'd15: v = 31'h00007FFF;
         5'd16: v = 31'h00003FFF;
         5'd17: v = 31'h00001FFF;
         5'd18: v = 31'h00000FFF;
         5'd19: v = 31'h000007FF;
         5'd20: v = 31'h000003FF;
         5'd21: v = 31'h000001FF;
         5'd22: v = 31'h000000FF;
         5'd23: v = 31'h0000007F;
         5'd24: v = 31'h0000003F;
         5'd25: v = 31'h0000001F;
         5'd26: v = 31'h0000000F;
         5'd27: v = 31'h00000008;
         5'd28: v = 31'h00000004;
         5'd29: v = 31'h00000002;
         default: v = 31'h0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/qte_front.sv -----
// qte_front: accepts quaternions, forms the products, classifies pole cases
// and prepares the angle arguments; depends on qte_pkg
module qte_front import qte_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_real_part,
   input  logic signed [DATA_WIDTH-1:0] req_i_part,
   input  logic signed [DATA_WIDTH-1:0] req_j_part,
   input  logic signed [DATA_WIDTH-1:0] req_k_part,
   input  logic [THR_W-1:0]             threshold,
   input  logic                         q_full,
   output logic                         q_push,
   output qte_item_type                 q_item
);

   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< (2 * INT_FRAC);

   logic [3:0] fv_ff;
   logic       en;
   logic signed [IN_W-1:0] w_in, x_in, y_in, z_in;
   logic signed [IN_W-1:0] w1_ff, x1_ff, y1_ff, z1_ff, w2_ff, x2_ff;
   logic signed [PROD_W-1:0] xy_ff, zw_ff, yw_ff, xz_ff, yy_ff, zz_ff, xw_ff, yz_ff, xx_ff;
   logic signed [SUM_W-1:0] test, thr, s, s_sh;
   qte_item_type item_in, item3_ff, item4_ff, item4_in;
   logic [S28_W-1:0] mag;

   assign en        = !(fv_ff[3] && q_full);
   assign req_ready = en;
   assign q_push    = fv_ff[3] && !q_full;
   assign q_item    = item4_ff;

   if (DATA_WIDTH - 2 <= INT_FRAC) begin : gen_up
      assign w_in = IN_W'(req_real_part) <<< (INT_FRAC - (DATA_WIDTH - 2));
      assign x_in = IN_W'(req_i_part) <<< (INT_FRAC - (DATA_WIDTH - 2));
      assign y_in = IN_W'(req_j_part) <<< (INT_FRAC - (DATA_WIDTH - 2));
      assign z_in = IN_W'(req_k_part) <<< (INT_FRAC - (DATA_WIDTH - 2));
   end else begin : gen_down
      assign w_in = IN_W'(req_real_part >>> (DATA_WIDTH - 2 - INT_FRAC));
      assign x_in = IN_W'(req_i_part >>> (DATA_WIDTH - 2 - INT_FRAC));
      assign y_in = IN_W'(req_j_part >>> (DATA_WIDTH - 2 - INT_FRAC));
      assign z_in = IN_W'(req_k_part >>> (DATA_WIDTH - 2 - INT_FRAC));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[2:0], req_valid};
      end
   end

   always_comb begin
      test = SUM_W'(xy_ff) + SUM_W'(zw_ff);
      thr  = $signed({{(SUM_W - THR_W - 30){1'b0}}, threshold, 30'b0});
      s    = test <<< 1;
      s_sh = s >>> (2 * INT_FRAC - 28);
      item_in.sq   = '0;
      item_in.s28  = s_sh[S28_W-1:0];
      item_in.ba_y = (SUM_W'(xw_ff) - SUM_W'(yz_ff)) <<< 1;
      item_in.ba_x = ONE - (SUM_W'(xx_ff) <<< 1) - (SUM_W'(zz_ff) <<< 1);
      if (test > thr) begin
         item_in.pole = POLE_NORTH;
         item_in.att  = ATT_POS;
         item_in.ha_y = SUM_W'(x2_ff);
         item_in.ha_x = SUM_W'(w2_ff);
      end else if (test < -thr) begin
         item_in.pole = POLE_SOUTH;
         item_in.att  = ATT_NEG;
         item_in.ha_y = SUM_W'(x2_ff);
         item_in.ha_x = SUM_W'(w2_ff);
      end else begin
         item_in.pole = POLE_NONE;
         item_in.ha_y = (SUM_W'(yw_ff) - SUM_W'(xz_ff)) <<< 1;
         item_in.ha_x = ONE - (SUM_W'(yy_ff) <<< 1) - (SUM_W'(zz_ff) <<< 1);
         if (s >= ONE) begin
            item_in.att = ATT_POS;
         end else if (s <= -ONE) begin
            item_in.att = ATT_NEG;
         end else begin
            item_in.att = ATT_CALC;
         end
      end
   end

   assign mag = item3_ff.s28[S28_W-1] ? S28_W'(-item3_ff.s28) : S28_W'(item3_ff.s28);

   always_comb begin
      item4_in    = item3_ff;
      item4_in.sq = RAD_W'(mag * mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff <= w_in;
         x1_ff <= x_in;
         y1_ff <= y_in;
         z1_ff <= z_in;
         w2_ff <= w1_ff;
         x2_ff <= x1_ff;
         xy_ff <= x1_ff * y1_ff;
         zw_ff <= z1_ff * w1_ff;
         yw_ff <= y1_ff * w1_ff;
         xz_ff <= x1_ff * z1_ff;
         yy_ff <= y1_ff * y1_ff;
         zz_ff <= z1_ff * z1_ff;
         xw_ff <= x1_ff * w1_ff;
         yz_ff <= y1_ff * z1_ff;
         xx_ff <= x1_ff * x1_ff;
         item3_ff <= item_in;
         item4_ff <= item4_in;
      end
   end

endmodule

// ----- src/qte_queue.sv -----
// qte_queue: short queue of classified items between front and back
// depends on qte_pkg
module qte_queue import qte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  qte_item_type push_item,
   output logic         full,
   output logic         q_valid,
   input  logic         q_ready,
   output qte_item_type q_item
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   qte_item_type    mem_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            pop;

   assign full    = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_item  = mem_ff[rd_ff];
   assign pop     = q_valid && q_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- src/qte_sqrt.sv -----
// qte_sqrt: pipelined digit-by-digit integer square root of 2^56 - sq
// depends on qte_pkg
module qte_sqrt import qte_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  sq,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] v_ff [0:SQRT_STEPS];
   logic [RAD_W-1:0] r_ff [0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0] <= (RAD_W'(1) << 56) - sq;
         r_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : gen_step
      localparam logic [RAD_W-1:0] B = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      logic [RAD_W-1:0] trial;
      assign trial = r_ff[j] + B;
      always_ff @(posedge clock) begin
         if (en) begin
            if (v_ff[j] >= trial) begin
               v_ff[j+1] <= v_ff[j] - trial;
               r_ff[j+1] <= (r_ff[j] >> 1) + B;
            end else begin
               v_ff[j+1] <= v_ff[j];
               r_ff[j+1] <= r_ff[j] >> 1;
            end
         end
      end
   end

   assign root = r_ff[SQRT_STEPS][ROOT_W-1:0];

endmodule

// ----- src/qte_cordic.sv -----
// qte_cordic: pipelined vectoring cordic giving atan2(y, x) in q30 radians,
// with staged normalization and half-plane pre-rotation; depends on qte_pkg
module qte_cordic import qte_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SUM_W-1:0] y_in,
   input  logic signed [SUM_W-1:0] x_in,
   output logic signed [ACC_W-1:0] angle
);

   localparam logic signed [ACC_W-1:0] HALF_PI = ACC_W'(HALF_PI_Q30);

   logic signed [CW-1:0] nx_ff [0:NORM_STAGES];
   logic signed [CW-1:0] ny_ff [0:NORM_STAGES];
   logic [CW-1:0]        nm_ff [0:NORM_STAGES];
   logic                 nz_ff [0:NORM_STAGES];
   logic signed [CW-1:0] cx_ff [0:STEPS];
   logic signed [CW-1:0] cy_ff [0:STEPS];
   logic signed [ACC_W-1:0] ca_ff [0:STEPS];
   logic                 cz_ff [0:STEPS];
   logic signed [CW-1:0] xe, ye, xa, ya;

   assign xe = CW'(x_in);
   assign ye = CW'(y_in);
   assign xa = xe[CW-1] ? -xe : xe;
   assign ya = ye[CW-1] ? -ye : ye;

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff[0] <= xe;
         ny_ff[0] <= ye;
         nm_ff[0] <= (xa > ya) ? xa : ya;
         nz_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar k = 0; k < NORM_STAGES; k++) begin : gen_norm
      localparam int SH = 32 >> k;
      localparam logic [CW-1:0] LIM = CW'(1) << (NORM_BIT + 1 - SH);
      always_ff @(posedge clock) begin
         if (en) begin
            nz_ff[k+1] <= nz_ff[k];
            if (nm_ff[k] < LIM) begin
               nx_ff[k+1] <= nx_ff[k] <<< SH;
               ny_ff[k+1] <= ny_ff[k] <<< SH;
               nm_ff[k+1] <= nm_ff[k] << SH;
            end else begin
               nx_ff[k+1] <= nx_ff[k];
               ny_ff[k+1] <= ny_ff[k];
               nm_ff[k+1] <= nm_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cz_ff[0] <= nz_ff[NORM_STAGES];
         if (nx_ff[NORM_STAGES][CW-1]) begin
            if (!ny_ff[NORM_STAGES][CW-1]) begin
               cx_ff[0] <= ny_ff[NORM_STAGES];
               cy_ff[0] <= -nx_ff[NORM_STAGES];
               ca_ff[0] <= HALF_PI;
            end else begin
               cx_ff[0] <= -ny_ff[NORM_STAGES];
               cy_ff[0] <= nx_ff[NORM_STAGES];
               ca_ff[0] <= -HALF_PI;
            end
         end else begin
            cx_ff[0] <= nx_ff[NORM_STAGES];
            cy_ff[0] <= ny_ff[NORM_STAGES];
            ca_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : gen_iter
      localparam logic signed [ACC_W-1:0] ATAN =
         $signed({{(ACC_W - 31){1'b0}}, atan_q30(5'(i))});
      logic signed [CW-1:0] dx, dy;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            cz_ff[i+1] <= cz_ff[i];
            if (cy_ff[i] > 0) begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               ca_ff[i+1] <= ca_ff[i] + ATAN;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               ca_ff[i+1] <= ca_ff[i] - ATAN;
            end
         end
      end
   end

   assign angle = cz_ff[STEPS] ? '0 : ca_ff[STEPS];

endmodule

// ----- src/qte_back.sv -----
// qte_back: square root, three cordic units, case selection and rounding
// to the response registers; depends on qte_pkg, qte_sqrt and qte_cordic
module qte_back import qte_pkg::*; #(
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  qte_item_type                 q_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_heading,
   output logic signed [DATA_WIDTH-1:0] rsp_attitude,
   output logic signed [DATA_WIDTH-1:0] rsp_bank,
   output logic [1:0]                   rsp_pole
);

   localparam int CL  = CORDIC_STEPS + CORDIC_PRE;
   localparam int LAT = SQRT_LAT + CL;
   localparam int HW  = ACC_W + 2;
   localparam int SH  = 30 - (DATA_WIDTH - 4);
   localparam logic signed [HW-1:0] HI  = HW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [HW-1:0] LO  = -HI - HW'(1);
   localparam logic signed [HW-1:0] RND = HW'(64'sd1 <<< (SH - 1));
   localparam logic signed [HW-1:0] HALF_PI = HW'(HALF_PI_Q30);

   logic                    en;
   logic [LAT-1:0]          vld_ff;
   logic                    rsp_valid_ff;
   logic signed [ACC_W-1:0] h_ang, b_ang, a_ang;
   logic signed [ACC_W-1:0] hd_ff [0:SQRT_LAT-1];
   logic signed [ACC_W-1:0] bd_ff [0:SQRT_LAT-1];
   logic signed [S28_W-1:0] sd_ff [0:SQRT_LAT-1];
   logic [1:0]              pd_ff [0:LAT-1];
   logic [1:0]              ad_ff [0:LAT-1];
   logic [ROOT_W-1:0]       root;
   logic signed [HW-1:0]    h_q, a_q, b_q;
   logic signed [DATA_WIDTH-1:0] heading_ff, attitude_ff, bank_ff;
   logic [1:0]              pole_ff;

   function automatic logic [DATA_WIDTH-1:0] angle_out(input logic signed [HW-1:0] a);
      logic signed [HW-1:0] v;
      v = (a + RND) >>> SH;
      if (v > HI) begin
         v = HI;
      end else if (v < LO) begin
         v = LO;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   assign en      = !rsp_valid_ff || rsp_ready;
   assign q_ready = en;

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_head (
      .clock (clock), .en (en), .y_in (q_item.ha_y), .x_in (q_item.ha_x), .angle (h_ang)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_bank (
      .clock (clock), .en (en), .y_in (q_item.ba_y), .x_in (q_item.ba_x), .angle (b_ang)
   );

   qte_sqrt u_sqrt (
      .clock (clock), .en (en), .sq (q_item.sq), .root (root)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_att (
      .clock (clock),
      .en    (en),
      .y_in  (SUM_W'(sd_ff[SQRT_LAT-1])),
      .x_in  ($signed({{(SUM_W - ROOT_W){1'b0}}, root})),
      .angle (a_ang)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= q_item.s28;
         pd_ff[0] <= q_item.pole;
         ad_ff[0] <= q_item.att;
         for (int k = 1; k < SQRT_LAT; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
         for (int k = 1; k < LAT; k++) begin
            pd_ff[k] <= pd_ff[k-1];
            ad_ff[k] <= ad_ff[k-1];
         end
         hd_ff[0] <= h_ang;
         bd_ff[0] <= b_ang;
         for (int k = 1; k < SQRT_LAT; k++) begin
            hd_ff[k] <= hd_ff[k-1];
            bd_ff[k] <= bd_ff[k-1];
         end
      end
   end

   always_comb begin
      h_q = HW'(hd_ff[SQRT_LAT-1]);
      case (pd_ff[LAT-1])
         POLE_NORTH: h_q = HW'(hd_ff[SQRT_LAT-1]) <<< 1;
         POLE_SOUTH: h_q = -(HW'(hd_ff[SQRT_LAT-1]) <<< 1);
         default:    h_q = HW'(hd_ff[SQRT_LAT-1]);
      endcase
      case (ad_ff[LAT-1])
         ATT_POS: a_q = HALF_PI;
         ATT_NEG: a_q = -HALF_PI;
         default: a_q = HW'(a_ang);
      endcase
      b_q = (pd_ff[LAT-1] == POLE_NONE) ? HW'(bd_ff[SQRT_LAT-1]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], q_valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff  <= angle_out(h_q);
         attitude_ff <= angle_out(a_q);
         bank_ff     <= angle_out(b_q);
         pole_ff     <= pd_ff[LAT-1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_heading  = heading_ff;
   assign rsp_attitude = attitude_ff;
   assign rsp_bank     = bank_ff;
   assign rsp_pole     = pole_ff;

endmodule

// ----- src/quaternion_to_euler_angles_top.sv -----
// quaternion_to_euler_angles_top: quaternion to heading, attitude and bank
// top level with pole threshold register; depends on qte_pkg, qte_front,
// qte_queue and qte_back
//
//   channel   handshake            payload
//   req       req_valid/req_ready  req_real_part, req_i_part, req_j_part, req_k_part
//   rsp       rsp_valid/rsp_ready  rsp_heading, rsp_attitude, rsp_bank, rsp_pole
//   csr       apb, pready tied     csr_paddr, csr_pwdata, csr_prdata
//
// one request per cycle sustained while the queue is not full, which a stalled
// response can cause; the 29-stage square root is followed by the cordic pipeline
// reset clears valid flags, queue pointers and sets pole_threshold to 8176
// a stalled response freezes the back pipeline; the 4-entry queue lets the
// front keep taking requests until it fills
module quaternion_to_euler_angles_top import qte_pkg::*; #(
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_real_part,
   input  logic signed [DATA_WIDTH-1:0] req_i_part,
   input  logic signed [DATA_WIDTH-1:0] req_j_part,
   input  logic signed [DATA_WIDTH-1:0] req_k_part,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_heading,
   output logic signed [DATA_WIDTH-1:0] rsp_attitude,
   output logic signed [DATA_WIDTH-1:0] rsp_bank,
   output logic [1:0]                   rsp_pole,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [THR_W-1:0] threshold_ff;
   logic             q_full, q_push, q_valid, q_ready;
   qte_item_type     push_item, q_item;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POLE_THRESHOLD) ?
                       {{(32 - THR_W){1'b0}}, threshold_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_W'(THR_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_POLE_THRESHOLD) begin
         threshold_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   qte_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_real_part (req_real_part),
      .req_i_part    (req_i_part),
      .req_j_part    (req_j_part),
      .req_k_part    (req_k_part),
      .threshold     (threshold_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   qte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   qte_back #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_heading  (rsp_heading),
      .rsp_attitude (rsp_attitude),
      .rsp_bank     (rsp_bank),
      .rsp_pole     (rsp_pole)
   );

endmodule
